// ===== rtl/kect_pkg.sv =====
// ----------------------------------------------------------------------------
// Keyed event counter table package
// Shared request and result types, controller command and status types,
// kind codes and the key canonicalisation function.
// ----------------------------------------------------------------------------
package kect_pkg;

  localparam int unsigned ENTRIES_DEF = 16;
  localparam int unsigned KEY_BYTES   = 31;
  localparam int unsigned KEY_W       = 8 * KEY_BYTES;
  localparam int unsigned CNT_W       = 32;
  localparam int unsigned SLOT_W      = CNT_W + 1;

  localparam logic [1:0] KIND_QUERY = 2'd0;
  localparam logic [1:0] KIND_INC   = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [63:0] key_bytes_0_7;
    logic [63:0] key_bytes_8_15;
    logic [63:0] key_bytes_16_23;
    logic [55:0] key_bytes_24_30;
  } req_t;

  typedef struct packed {
    logic             found;
    logic [CNT_W-1:0] count;
    logic             dirty;
    logic             dropped;
  } rsp_t;

  typedef struct packed {
    logic load;
    logic search;
    logic finish;
  } ctl_cmd_t;

  typedef struct packed {
    logic done;
  } ctl_sts_t;

  // Every byte after the first zero byte is forced to zero.
  function automatic logic [KEY_W-1:0] canon_key(input req_t req);
    logic [KEY_W-1:0]     raw;
    logic [KEY_W-1:0]     res;
    logic [KEY_BYTES-1:0] nz;
    logic [KEY_BYTES-1:0] first_zero;
    logic [KEY_BYTES-1:0] keep;
    raw = {req.key_bytes_24_30, req.key_bytes_16_23, req.key_bytes_8_15, req.key_bytes_0_7};
    for (int i = 0; i < KEY_BYTES; i++) begin
      nz[i] = |raw[8*i +: 8];
    end
    first_zero = ~nz & (nz + KEY_BYTES'(1));
    keep       = first_zero | (first_zero - KEY_BYTES'(1));
    for (int i = 0; i < KEY_BYTES; i++) begin
      res[8*i +: 8] = keep[i] ? raw[8*i +: 8] : 8'h00;
    end
    return res;
  endfunction

endpackage

// ===== rtl/keyed_event_counter_table.sv =====
// The request is loaded, then the key memory is walked one slot a cycle until the key
// matches or the last slot is compared, then the finish state updates the slot and
// registers the result. A new request is taken only in the idle state, once the walk
// is through. busy falls in the cycle that shows the result.
// Reset clears the slot valid bits at once, so the table is empty and usable
// in the first cycle after reset; results cannot be held off by the receiver.
// ----------------------------------------------------------------------------
// Keyed event counter table
// A table of slots, each with a 31-byte key, a 32-bit event counter and a
// dirty flag, serving query, increment and clear requests.
// ----------------------------------------------------------------------------
module keyed_event_counter_table #(
  parameter int unsigned ENTRIES = kect_pkg::ENTRIES_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  kect_pkg::req_t req_i,
  output logic           result_stb_o,
  output kect_pkg::rsp_t result_o
);

  import kect_pkg::*;

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  kect_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .cmd_o  (cmd),
    .sts_i  (sts)
  );

  kect_dpath #(
    .ENTRIES (ENTRIES)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .result_stb_o (result_stb_o),
    .result_o     (result_o)
  );

endmodule

// ===== rtl/kect_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, with registered read data.
// ----------------------------------------------------------------------------
module kect_ram #(
  parameter int unsigned WIDTH = kect_pkg::KEY_W,
  parameter int unsigned DEPTH = kect_pkg::ENTRIES_DEF,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/kect_ctrl.sv =====
// ----------------------------------------------------------------------------
// Keyed event counter table controller
// Sequences a request through the slot search and the final update.
// ----------------------------------------------------------------------------
module kect_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  output kect_pkg::ctl_cmd_t cmd_o,
  input  kect_pkg::ctl_sts_t sts_i
);

  import kect_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SEARCH = 3'b010,
    ST_FINISH = 3'b100
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        cmd_o.search = 1'b1;
        if (sts_i.done) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        cmd_o.finish = 1'b1;
        state_d      = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != ST_IDLE);

endmodule

// ===== rtl/kect_dpath.sv =====
// ----------------------------------------------------------------------------
// Keyed event counter table datapath
// Holds the slot valid bits, the key and counter memories, the search
// pipeline and the result register.
// ----------------------------------------------------------------------------
module kect_dpath #(
  parameter int unsigned ENTRIES = kect_pkg::ENTRIES_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  kect_pkg::req_t     req_i,
  input  kect_pkg::ctl_cmd_t cmd_i,
  output kect_pkg::ctl_sts_t sts_o,
  output logic               result_stb_o,
  output kect_pkg::rsp_t     result_o
);

  import kect_pkg::*;

  localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [IW-1:0] LAST = IW'(ENTRIES - 1);

  logic [ENTRIES-1:0] valid_q, valid_d;
  logic [KEY_W-1:0]   key_q;
  logic [1:0]         kind_q;
  logic [IW-1:0]      rd_idx_q, rd_idx_d;
  logic               iss_q, iss_d;
  logic               cmp_v_q, cmp_v_d;
  logic [IW-1:0]      cmp_idx_q, cmp_idx_d;
  logic               hit_q, hit_d;
  logic [IW-1:0]      slot_q, slot_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               dirty_q, dirty_d;
  logic               free_v_q, free_v_d;
  logic [IW-1:0]      free_idx_q, free_idx_d;
  logic               stb_q, stb_d;
  rsp_t               res_q, res_d;

  logic [KEY_W-1:0]   key_rdata;
  logic [SLOT_W-1:0]  slot_rdata;
  logic               key_we;
  logic               slot_we;
  logic [IW-1:0]      waddr;
  logic [SLOT_W-1:0]  slot_wdata;
  logic               cmp_hit;
  logic               is_inc;
  logic               is_clr;

  kect_ram #(
    .WIDTH (KEY_W),
    .DEPTH (ENTRIES),
    .AW    (IW)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (waddr),
    .wdata_i (key_q),
    .raddr_i (rd_idx_q),
    .rdata_o (key_rdata)
  );

  kect_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (ENTRIES),
    .AW    (IW)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (slot_we),
    .waddr_i (waddr),
    .wdata_i (slot_wdata),
    .raddr_i (rd_idx_q),
    .rdata_o (slot_rdata)
  );

  assign cmp_hit    = cmp_v_q && valid_q[cmp_idx_q] && (key_rdata == key_q);
  assign sts_o.done = cmp_v_q && (cmp_hit || (cmp_idx_q == LAST));
  assign is_inc     = (kind_q == KIND_INC);
  assign is_clr     = (kind_q == KIND_CLEAR);

  always_comb begin
    valid_d    = valid_q;
    rd_idx_d   = rd_idx_q;
    iss_d      = iss_q;
    cmp_v_d    = cmp_v_q;
    cmp_idx_d  = cmp_idx_q;
    hit_d      = hit_q;
    slot_d     = slot_q;
    cnt_d      = cnt_q;
    dirty_d    = dirty_q;
    free_v_d   = free_v_q;
    free_idx_d = free_idx_q;
    stb_d      = 1'b0;
    res_d      = res_q;
    key_we     = 1'b0;
    slot_we    = 1'b0;
    waddr      = hit_q ? slot_q : free_idx_q;
    slot_wdata = '0;

    if (cmd_i.load) begin
      rd_idx_d = '0;
      iss_d    = 1'b1;
      cmp_v_d  = 1'b0;
      hit_d    = 1'b0;
      free_v_d = 1'b0;
    end

    if (cmd_i.search) begin
      cmp_v_d   = iss_q;
      cmp_idx_d = rd_idx_q;
      if (iss_q) begin
        if (rd_idx_q == LAST) begin
          iss_d = 1'b0;
        end else begin
          rd_idx_d = rd_idx_q + IW'(1);
        end
      end
      if (cmp_v_q) begin
        if (cmp_hit) begin
          hit_d   = 1'b1;
          slot_d  = cmp_idx_q;
          cnt_d   = slot_rdata[CNT_W-1:0];
          dirty_d = slot_rdata[CNT_W];
        end
        if (!valid_q[cmp_idx_q] && !free_v_q) begin
          free_v_d   = 1'b1;
          free_idx_d = cmp_idx_q;
        end
      end
    end

    if (cmd_i.finish) begin
      stb_d = 1'b1;
      res_d = '0;
      if (is_inc) begin
        if (hit_q) begin
          slot_wdata    = {1'b1, CNT_W'(cnt_q + CNT_W'(1))};
          slot_we       = 1'b1;
          res_d.found   = 1'b1;
          res_d.count   = CNT_W'(cnt_q + CNT_W'(1));
          res_d.dirty   = 1'b1;
        end else if (free_v_q) begin
          slot_wdata         = {1'b1, CNT_W'(1)};
          slot_we            = 1'b1;
          key_we             = 1'b1;
          valid_d[free_idx_q] = 1'b1;
          res_d.found        = 1'b1;
          res_d.count        = CNT_W'(1);
          res_d.dirty        = 1'b1;
        end else begin
          res_d.dropped = 1'b1;
        end
      end else if (is_clr) begin
        if (hit_q) begin
          slot_we     = 1'b1;
          res_d.found = 1'b1;
        end
      end else if (hit_q) begin
        res_d.found = 1'b1;
        res_d.count = cnt_q;
        res_d.dirty = dirty_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      iss_q    <= 1'b0;
      cmp_v_q  <= 1'b0;
      hit_q    <= 1'b0;
      free_v_q <= 1'b0;
      stb_q    <= 1'b0;
    end else begin
      valid_q  <= valid_d;
      iss_q    <= iss_d;
      cmp_v_q  <= cmp_v_d;
      hit_q    <= hit_d;
      free_v_q <= free_v_d;
      stb_q    <= stb_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      key_q  <= canon_key(req_i);
      kind_q <= req_i.kind;
    end
    rd_idx_q   <= rd_idx_d;
    cmp_idx_q  <= cmp_idx_d;
    slot_q     <= slot_d;
    cnt_q      <= cnt_d;
    dirty_q    <= dirty_d;
    free_idx_q <= free_idx_d;
    res_q      <= res_d;
  end

  assign result_stb_o = stb_q;
  assign result_o     = res_q;

endmodule
